/* rtl/rpcf_pkg.sv */
// Package for the RGB pixel color filter: constants, codes and the weighting function.
`timescale 1ns / 1ps
package rpcf_pkg;

   localparam int CHAN_W    = 8;
   localparam int FRAC_W    = 16;
   localparam int FACTOR_W  = FRAC_W + 1;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = FACTOR_W;
   localparam int COEF_W    = 16;
   localparam int SUM_W     = COEF_W + CHAN_W + 2;

   localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1 << FRAC_W);
   localparam logic [CHAN_W-1:0]   CHAN_MAX   = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_GRAY   = 3'd0,
      MODE_SEPIA  = 3'd1,
      MODE_INVERT = 3'd2,
      MODE_SHADE  = 3'd3,
      MODE_TINT   = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FILTER_MODE  = 2'd0,
      REG_BLEND_FACTOR = 2'd1
   } csr_reg_type;

   typedef logic [COEF_W-1:0] coef_type;
   typedef logic [CHAN_W-1:0] chan_type;

   localparam coef_type LUMA_R = 16'd13933;
   localparam coef_type LUMA_G = 16'd46871;
   localparam coef_type LUMA_B = 16'd4732;

   localparam coef_type SEPIA_RR = 16'd25756;
   localparam coef_type SEPIA_RG = 16'd50397;
   localparam coef_type SEPIA_RB = 16'd12386;
   localparam coef_type SEPIA_GR = 16'd22872;
   localparam coef_type SEPIA_GG = 16'd44958;
   localparam coef_type SEPIA_GB = 16'd11010;
   localparam coef_type SEPIA_BR = 16'd17826;
   localparam coef_type SEPIA_BG = 16'd34996;
   localparam coef_type SEPIA_BB = 16'd8585;

   // weighted sum of three channels, drop fraction, clamp at full scale
   function automatic chan_type weigh3(input coef_type w0, input coef_type w1,
                                       input coef_type w2, input chan_type r,
                                       input chan_type g, input chan_type b);
      logic [SUM_W-1:0]          sum;
      logic [SUM_W-FRAC_W-1:0]   whole;
      sum = SUM_W'(w0) * SUM_W'(r) + SUM_W'(w1) * SUM_W'(g) + SUM_W'(w2) * SUM_W'(b);
      whole = sum[SUM_W-1:FRAC_W];
      if (whole > (SUM_W-FRAC_W)'(CHAN_MAX)) begin
         return CHAN_MAX;
      end
      return whole[CHAN_W-1:0];
   endfunction

endpackage

/* rtl/rgb_pixel_color_filter.sv */
// Top level of the RGB pixel color filter: input register, filter logic, result register.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_red_in, req_green_in, req_blue_in
//   rsp      out        rsp_valid/stall    rsp_red_out, rsp_green_out, rsp_blue_out
//   csr      in         csr_write          csr_index, csr_wdata
//
// One word per cycle unless rsp_stall blocks; words pass input then result register.
// Per channel, between registers: a constant-weight sum, an 8x17 product or a subtraction.
// Synchronous reset clears both valid bits and the CSRs (grayscale, factor zero).
// A stalled result holds; the input stage keeps taking words while the result stage can drain.
`timescale 1ns / 1ps
module rgb_pixel_color_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rpcf_pkg::CHAN_W-1:0]       req_red_in,
   input  logic [rpcf_pkg::CHAN_W-1:0]       req_green_in,
   input  logic [rpcf_pkg::CHAN_W-1:0]       req_blue_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rpcf_pkg::CHAN_W-1:0]       rsp_red_out,
   output logic [rpcf_pkg::CHAN_W-1:0]       rsp_green_out,
   output logic [rpcf_pkg::CHAN_W-1:0]       rsp_blue_out,
   input  logic                              csr_write,
   input  logic [rpcf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpcf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rpcf_pkg::*;

   logic [MODE_W-1:0]    mode_ff;
   logic [FACTOR_W-1:0]  factor_ff;

   logic                 s1_valid_ff;
   chan_type             s1_red_ff, s1_green_ff, s1_blue_ff;
   logic                 s2_valid_ff;
   chan_type             s2_red_ff, s2_green_ff, s2_blue_ff;

   logic                 s2_open;
   logic                 s2_load;
   logic                 s1_open;
   logic                 s1_valid_in;
   logic                 s2_valid_in;
   chan_type             red_in, green_in, blue_in;

   logic [FACTOR_W-1:0]  factor_sat;
   logic [FACTOR_W-1:0]  keep_frac;
   chan_type             chan_src [3];
   chan_type             chan_res [3];
   chan_type             gray;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_W'(MODE_GRAY);
         factor_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_FILTER_MODE:  mode_ff   <= csr_wdata[MODE_W-1:0];
            REG_BLEND_FACTOR: factor_ff <= csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: result stage drains or is empty, input stage moves forward
   assign s2_open     = !s2_valid_ff || !rsp_stall;
   assign s2_load     = s1_valid_ff && s2_open;
   assign s1_open     = !s1_valid_ff || s2_open;
   assign req_stall   = !s1_open;
   assign s1_valid_in = s1_open ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_open ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_open) begin
         s1_red_ff   <= req_red_in;
         s1_green_ff <= req_green_in;
         s1_blue_ff  <= req_blue_in;
      end
   end

   // filter datapath
   assign factor_sat = factor_ff[FACTOR_W-1] ? FACTOR_ONE : factor_ff;
   assign keep_frac  = FACTOR_ONE - factor_sat;
   assign chan_src[0] = s1_red_ff;
   assign chan_src[1] = s1_green_ff;
   assign chan_src[2] = s1_blue_ff;
   assign gray = weigh3(LUMA_R, LUMA_G, LUMA_B, s1_red_ff, s1_green_ff, s1_blue_ff);

   always_comb begin
      logic [CHAN_W+FACTOR_W-1:0] prod;
      prod = '0;
      for (int k = 0; k < 3; k++) begin
         case (mode_type'(mode_ff))
            MODE_GRAY: begin
               chan_res[k] = gray;
            end
            MODE_SEPIA: begin
               chan_res[k] = chan_src[k];
            end
            MODE_INVERT: begin
               chan_res[k] = CHAN_MAX - chan_src[k];
            end
            MODE_SHADE: begin
               prod = (CHAN_W+FACTOR_W)'(chan_src[k]) * (CHAN_W+FACTOR_W)'(keep_frac);
               chan_res[k] = prod[FRAC_W +: CHAN_W];
            end
            MODE_TINT: begin
               prod = (CHAN_W+FACTOR_W)'(CHAN_MAX - chan_src[k])
                      * (CHAN_W+FACTOR_W)'(factor_sat);
               chan_res[k] = chan_src[k] + prod[FRAC_W +: CHAN_W];
            end
            default: begin
               chan_res[k] = chan_src[k];
            end
         endcase
      end
   end

   always_comb begin
      if (mode_type'(mode_ff) == MODE_SEPIA) begin
         red_in   = weigh3(SEPIA_RR, SEPIA_RG, SEPIA_RB, s1_red_ff, s1_green_ff, s1_blue_ff);
         green_in = weigh3(SEPIA_GR, SEPIA_GG, SEPIA_GB, s1_red_ff, s1_green_ff, s1_blue_ff);
         blue_in  = weigh3(SEPIA_BR, SEPIA_BG, SEPIA_BB, s1_red_ff, s1_green_ff, s1_blue_ff);
      end else begin
         red_in   = chan_res[0];
         green_in = chan_res[1];
         blue_in  = chan_res[2];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_red_ff   <= red_in;
         s2_green_ff <= green_in;
         s2_blue_ff  <= blue_in;
      end
   end

   assign rsp_valid     = s2_valid_ff;
   assign rsp_red_out   = s2_red_ff;
   assign rsp_green_out = s2_green_ff;
   assign rsp_blue_out  = s2_blue_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> rsp_valid)
      else $error("loaded word missing at result");

   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      (s2_load && mode_ff == MODE_W'(MODE_GRAY))
      |=> (rsp_red_out == rsp_green_out && rsp_green_out == rsp_blue_out))
      else $error("grayscale channels differ");

   a_invert: assert property (@(posedge clock) disable iff (reset)
      (s2_load && mode_ff == MODE_W'(MODE_INVERT))
      |=> (rsp_red_out == ~$past(s1_red_ff) && rsp_blue_out == ~$past(s1_blue_ff)))
      else $error("invert result wrong");

endmodule
